// File: design/acem_pkg.sv
// ============================================================================
// acem_pkg: shared constants and types of the three-channel converter monitor
// Scaling constants, field widths and the record passed from the scaling
// front end through the queue to the filter back end.
// ============================================================================
`default_nettype none

package acem_pkg;

    // Default converter sample width.
    localparam int SAMPLE_BITS_DEF = 10;

    // Result field widths.
    localparam int BAT_W  = 12;
    localparam int RAIL_W = 13;
    localparam int TEMP_W = 13;

    // Scaling constants. The ratios 10000/2744, 1000/2744 and 16000/2744
    // are reduced to 1250/343, 125/343 and 2000/343.
    localparam int BAT_MUL       = 1250;
    localparam int RAIL_MUL      = 125;
    localparam int RAIL_MUL_INIT = 2000;
    localparam int RAIL_DIV      = 343;
    localparam int TEMP_OFFSET   = 121;
    localparam int TEMP_DIV      = 6;

    // Filter constants: keep 15/16 of the old value.
    localparam int KEEP         = 15;
    localparam int SHRINK_SHIFT = 4;

    // Saturation limits.
    localparam int BAT_MAX_I  = 4095;
    localparam int RAIL_MAX_I = 8191;
    localparam int TEMP_MAX_I = 4095;
    localparam int TEMP_MIN_I = -4096;

    // Queue between front and back (depth is a power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Scaled values of one conversion set.
    typedef struct packed {
        logic        [BAT_W-1:0]  bat_scaled;
        logic        [RAIL_W-1:0] rail_scaled;
        logic        [RAIL_W-1:0] rail_init;
        logic signed [TEMP_W-1:0] temp_scaled;
        logic signed [TEMP_W-1:0] temp_init;
    } scaled_t;

    // Write side of the queue.
    typedef struct packed {
        logic    push;
        scaled_t data;
    } q_wr_t;

    // Read side of the queue.
    typedef struct packed {
        logic    valid;
        scaled_t data;
    } q_rd_t;

endpackage

`default_nettype wire

// File: design/acem_front.sv
// ============================================================================
// acem_front: scaling front end
// Two-stage pipeline. Stage one forms the constant products and the
// temperature quotient; stage two divides by 343 through reciprocal
// multiplication, saturates, and pushes the record into the queue.
// ============================================================================
`default_nettype none

module acem_front #(
    parameter int SAMPLE_BITS = acem_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] battery_sample,
    input  logic [SAMPLE_BITS-1:0] supply12_sample,
    input  logic [SAMPLE_BITS-1:0] temp_sample,
    input  logic                   q_full,
    output acem_pkg::q_wr_t        q_wr
);
    import acem_pkg::*;

    // Divide by 343: exact for products below 2**DIVN.
    localparam int DIVN = SAMPLE_BITS + 11;
    localparam int DIVK = DIVN + 9;
    localparam int MW   = DIVK - 8;
    localparam int QW   = DIVN - 8;
    localparam logic [63:0] M343_FULL =
        ((64'd1 << DIVK) + 64'(RAIL_DIV) - 64'd1) / 64'(RAIL_DIV);
    localparam logic [MW-1:0] M343 = M343_FULL[MW-1:0];

    // Divide by 6: exact for magnitudes below 2**SAMPLE_BITS.
    localparam int TK  = SAMPLE_BITS + 3;
    localparam int TQW = SAMPLE_BITS - 2;
    localparam logic [63:0] M6_FULL =
        ((64'd1 << TK) + 64'(TEMP_DIV) - 64'd1) / 64'(TEMP_DIV);
    localparam logic [SAMPLE_BITS:0] M6 = M6_FULL[SAMPLE_BITS:0];

    // Reciprocal division by 343.
    function automatic logic [QW-1:0] div343(input logic [DIVN-1:0] x);
        logic [DIVN+MW-1:0] prod;
        prod = (DIVN+MW)'(x) * (DIVN+MW)'(M343);
        return prod[DIVN+MW-1:DIVK];
    endfunction

    // Pipeline registers.
    logic                   s1_valid_reg, s1_valid_next;
    logic [DIVN-1:0]        s1_bat_reg;
    logic [DIVN-1:0]        s1_rail_reg;
    logic [DIVN-1:0]        s1_init_reg;
    logic [TQW-1:0]         s1_tq_reg;
    logic                   s1_tneg_reg;
    logic                   s2_valid_reg, s2_valid_next;
    scaled_t                s2_data_reg, s2_data_next;

    logic                   accept, s1_move, s2_move, s2_free;
    logic signed [SAMPLE_BITS:0] t_diff;
    logic [SAMPLE_BITS:0]   t_negated;
    logic [SAMPLE_BITS-1:0] t_mag;
    logic [2*SAMPLE_BITS:0] t_prod;

    logic [QW-1:0]          bat_q, rail_q, init_q;
    logic [TEMP_W-1:0]      tq_ext;
    logic signed [TEMP_W-1:0] ts;
    logic signed [TEMP_W+SHRINK_SHIFT-1:0] ti_wide;

    // Handshake through the two stages.
    assign s2_move  = s2_valid_reg && !q_full;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    // Temperature offset removal and magnitude for truncating division.
    assign t_diff    = $signed({1'b0, temp_sample})
                     - $signed((SAMPLE_BITS+1)'(TEMP_OFFSET));
    assign t_negated = -t_diff;
    assign t_mag     = t_diff[SAMPLE_BITS] ? t_negated[SAMPLE_BITS-1:0]
                                           : t_diff[SAMPLE_BITS-1:0];
    assign t_prod    = (2*SAMPLE_BITS+1)'(t_mag) * (2*SAMPLE_BITS+1)'(M6);

    // Stage one capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bat_reg  <= DIVN'(battery_sample) * DIVN'(BAT_MUL);
            s1_rail_reg <= DIVN'(supply12_sample) * DIVN'(RAIL_MUL);
            s1_init_reg <= DIVN'(supply12_sample) * DIVN'(RAIL_MUL_INIT);
            s1_tq_reg   <= t_prod[2*SAMPLE_BITS:TK];
            s1_tneg_reg <= t_diff[SAMPLE_BITS];
        end
    end

    // Stage two: division by 343, sign restore and saturation.
    always_comb
    begin
        bat_q  = div343(s1_bat_reg);
        rail_q = div343(s1_rail_reg);
        init_q = div343(s1_init_reg);
        tq_ext = TEMP_W'(s1_tq_reg);
        ts     = s1_tneg_reg ? -$signed(tq_ext) : $signed(tq_ext);
        ti_wide = $signed({{SHRINK_SHIFT{ts[TEMP_W-1]}}, ts}) <<< SHRINK_SHIFT;

        s2_data_next.bat_scaled  = (int'(bat_q) > BAT_MAX_I) ? '1 : BAT_W'(bat_q);
        s2_data_next.rail_scaled = (int'(rail_q) > RAIL_MAX_I) ? '1 : RAIL_W'(rail_q);
        s2_data_next.rail_init   = (int'(init_q) > RAIL_MAX_I) ? '1 : RAIL_W'(init_q);
        s2_data_next.temp_scaled = ts;
        if (ti_wide > $signed((TEMP_W+SHRINK_SHIFT)'(TEMP_MAX_I)))
        begin
            s2_data_next.temp_init = $signed(TEMP_W'(TEMP_MAX_I));
        end
        else if (ti_wide < $signed((TEMP_W+SHRINK_SHIFT)'(TEMP_MIN_I)))
        begin
            s2_data_next.temp_init = $signed(TEMP_W'(TEMP_MIN_I));
        end
        else
        begin
            s2_data_next.temp_init = ti_wide[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    // Stage valid bits.
    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    assign q_wr.push = s2_move;
    assign q_wr.data = s2_data_reg;

endmodule

`default_nettype wire

// File: design/acem_queue.sv
// ============================================================================
// acem_queue: record queue between front and back
// Small register FIFO that lets the scaling front end and the filter back
// end stall independently.
// ============================================================================
`default_nettype none

module acem_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  acem_pkg::q_wr_t wr,
    output logic            full,
    input  logic            pop,
    output acem_pkg::q_rd_t rd
);
    import acem_pkg::*;

    scaled_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.data  = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(wr.push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/acem_back.sv
// ============================================================================
// acem_back: filter back end
// Pops one scaled record per cycle unless the output stalls, updates the
// three filters and holds the result in the output register until taken.
// ============================================================================
`default_nettype none

module acem_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  acem_pkg::q_rd_t                    rd,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [acem_pkg::BAT_W-1:0]  battery_filtered,
    output logic        [acem_pkg::BAT_W-1:0]  battery_instant,
    output logic        [acem_pkg::RAIL_W-1:0] supply12_filtered,
    output logic signed [acem_pkg::TEMP_W-1:0] temp_filtered
);
    import acem_pkg::*;

    localparam int BSUM_W = BAT_W + SHRINK_SHIFT;
    localparam int RP_W   = RAIL_W + SHRINK_SHIFT;
    localparam int TP_W   = TEMP_W + SHRINK_SHIFT;

    logic                     out_valid_reg, out_valid_next;
    logic                     primed_reg;
    logic        [BAT_W-1:0]  bat_avg_reg, bat_avg_next;
    logic        [BAT_W-1:0]  bat_inst_reg;
    logic        [RAIL_W-1:0] rail_avg_reg, rail_avg_next;
    logic signed [TEMP_W-1:0] temp_avg_reg, temp_avg_next;

    logic        [BSUM_W-1:0] bat_sum;
    logic        [RP_W-1:0]   rail_prod;
    logic        [RAIL_W:0]   rail_sum;
    logic signed [TP_W-1:0]   temp_prod, temp_adj, temp_quot;
    logic signed [TEMP_W:0]   temp_sum;

    assign pop = rd.valid && (!out_valid_reg || out_ready);

    // Filter recurrences.
    always_comb
    begin
        // Battery: (new + 15*old) / 16, never above the 12-bit range.
        bat_sum = BSUM_W'(rd.data.bat_scaled) + BSUM_W'(bat_avg_reg) * BSUM_W'(KEEP);

        // 12 V: new + floor(15*old/16), saturated.
        rail_prod = RP_W'(rail_avg_reg) * RP_W'(KEEP);
        rail_sum  = (RAIL_W+1)'(rd.data.rail_scaled)
                  + (RAIL_W+1)'(rail_prod[RP_W-1:SHRINK_SHIFT]);

        // Temperature: new + 15*old/16 truncated toward zero, saturated.
        temp_prod = $signed({{SHRINK_SHIFT{temp_avg_reg[TEMP_W-1]}}, temp_avg_reg})
                  * $signed(TP_W'(KEEP));
        temp_adj  = temp_prod[TP_W-1] ? temp_prod + $signed(TP_W'(KEEP)) : temp_prod;
        temp_quot = temp_adj >>> SHRINK_SHIFT;
        temp_sum  = $signed({rd.data.temp_scaled[TEMP_W-1], rd.data.temp_scaled})
                  + $signed(temp_quot[TEMP_W:0]);

        if (!primed_reg)
        begin
            bat_avg_next  = rd.data.bat_scaled;
            rail_avg_next = rd.data.rail_init;
            temp_avg_next = rd.data.temp_init;
        end
        else
        begin
            bat_avg_next  = bat_sum[BSUM_W-1:SHRINK_SHIFT];
            rail_avg_next = (int'(rail_sum) > RAIL_MAX_I) ? '1 : rail_sum[RAIL_W-1:0];
            if (temp_sum > $signed((TEMP_W+1)'(TEMP_MAX_I)))
            begin
                temp_avg_next = $signed(TEMP_W'(TEMP_MAX_I));
            end
            else if (temp_sum < $signed((TEMP_W+1)'(TEMP_MIN_I)))
            begin
                temp_avg_next = $signed(TEMP_W'(TEMP_MIN_I));
            end
            else
            begin
                temp_avg_next = temp_sum[TEMP_W-1:0];
            end
        end
    end

    // Instant battery value travels with the result.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bat_inst_reg <= rd.data.bat_scaled;
        end
    end

    assign out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Filter state doubles as the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            bat_avg_reg   <= '0;
            rail_avg_reg  <= '0;
            temp_avg_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                primed_reg   <= 1'b1;
                bat_avg_reg  <= bat_avg_next;
                rail_avg_reg <= rail_avg_next;
                temp_avg_reg <= temp_avg_next;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign battery_filtered  = bat_avg_reg;
    assign battery_instant   = bat_inst_reg;
    assign supply12_filtered = rail_avg_reg;
    assign temp_filtered     = temp_avg_reg;

endmodule

`default_nettype wire

// File: design/adc_three_channel_ema_monitor.sv
// ============================================================================
// Throughput: one conversion set per cycle unless the output stalls; the
// two-stage scaling pipeline, the 4-entry queue and the filter register
// each advance one item a cycle. A set passes them in that order.
// Reset: asynchronous, active low; clears all valid bits, the queue and the
// filters, and the first set after reset loads the filters directly.
// adc_three_channel_ema_monitor: three-channel converter monitor top level
// ============================================================================
`default_nettype none

module adc_three_channel_ema_monitor #(
    parameter int SAMPLE_BITS = acem_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic        [SAMPLE_BITS-1:0]      battery_sample,
    input  logic        [SAMPLE_BITS-1:0]      supply12_sample,
    input  logic        [SAMPLE_BITS-1:0]      temp_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [acem_pkg::BAT_W-1:0]  battery_filtered,
    output logic        [acem_pkg::BAT_W-1:0]  battery_instant,
    output logic        [acem_pkg::RAIL_W-1:0] supply12_filtered,
    output logic signed [acem_pkg::TEMP_W-1:0] temp_filtered
);
    import acem_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    // Scaling front end.
    acem_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .battery_sample  (battery_sample),
        .supply12_sample (supply12_sample),
        .temp_sample     (temp_sample),
        .q_full          (q_full),
        .q_wr            (q_wr)
    );

    // Decoupling queue.
    acem_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .rd    (q_rd)
    );

    // Filter back end.
    acem_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .rd                (q_rd),
        .pop               (q_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .battery_filtered  (battery_filtered),
        .battery_instant   (battery_instant),
        .supply12_filtered (supply12_filtered),
        .temp_filtered     (temp_filtered)
    );

endmodule

`default_nettype wire

// File: design/acem_checker.sv
// ============================================================================
// acem_checker: port-level checks of the converter monitor
// Tracks items in flight and checks output hold, item conservation and
// the direct load of the first set.
// ============================================================================
`default_nettype none

module acem_checker (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    input  wire                               in_ready,
    input  wire                               out_valid,
    input  wire                               out_ready,
    input  wire        [acem_pkg::BAT_W-1:0]  battery_filtered,
    input  wire        [acem_pkg::BAT_W-1:0]  battery_instant,
    input  wire        [acem_pkg::RAIL_W-1:0] supply12_filtered,
    input  wire signed [acem_pkg::TEMP_W-1:0] temp_filtered
);
    import acem_pkg::*;

    // Two front stages, the queue and the output register.
    localparam int CAPACITY = 2 + QUEUE_DEPTH + 1;
    localparam int PEND_W   = $clog2(CAPACITY + 2);

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic              seen_out_reg;
    logic              in_acc, out_acc;

    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid && out_ready;
    assign pending_next = pending_reg + PEND_W'(in_acc) - PEND_W'(out_acc);

    // Items in flight and first-result tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            seen_out_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_acc)
            begin
                seen_out_reg <= 1'b1;
            end
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its fields.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(battery_filtered)
            && $stable(battery_instant) && $stable(supply12_filtered)
            && $stable(temp_filtered))
        else $error("result changed while stalled");

    // No result without an accepted set behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result offered with no item in flight");

    // The block never holds more items than it has room for.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pending_reg) <= CAPACITY)
        else $error("more items in flight than storage allows");

    // The first result loads the battery average with the instant value.
    a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !seen_out_reg |-> battery_filtered == battery_instant)
        else $error("first battery average differs from instant value");

endmodule

bind adc_three_channel_ema_monitor acem_checker u_acem_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .battery_filtered  (battery_filtered),
    .battery_instant   (battery_instant),
    .supply12_filtered (supply12_filtered),
    .temp_filtered     (temp_filtered)
);

`default_nettype wire
